[sv/vcpq_pkg.sv]
// ----------------------------------------------------------------------------
// vcpq_pkg
// Types and constants shared by the virtual channel priority queue block.
// ----------------------------------------------------------------------------
package vcpq_pkg;

	localparam int CFG_CHANNELS = 8;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_CHAN_OFF = 3'd1;
	localparam logic [2:0] RC_LEN_BAD  = 3'd2;
	localparam logic [2:0] RC_FULL     = 3'd3;
	localparam logic [2:0] RC_EMPTY    = 3'd4;

	localparam logic [2:0] CFG_ENABLE_MASK = 3'd0;
	localparam logic [2:0] CFG_PRIORITIES  = 3'd1;
	localparam logic [2:0] CFG_LEN_LOW     = 3'd2;
	localparam logic [2:0] CFG_LEN_HIGH    = 3'd3;
	localparam logic [2:0] CFG_QUEUE_LIMIT = 3'd4;

	localparam logic [4:0] QUEUE_LIMIT_RESET = 5'd16;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  channel_id;
		logic [15:0] buffer_ref;
		logic [15:0] sdu_length;
		logic [7:0]  sdu_status;
	} item_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [2:0]  served_channel;
		logic [15:0] served_buffer_ref;
		logic [15:0] served_length;
		logic [7:0]  served_status;
		logic        any_pending;
	} result_t;

	typedef struct packed {
		logic [7:0]  status;
		logic [15:0] length;
		logic [15:0] buffer_ref;
	} entry_t;

endpackage

[sv/virtual_channel_priority_queues.sv]
// ----------------------------------------------------------------------------
// virtual_channel_priority_queues
// Per-channel descriptor FIFOs with a strict priority dequeue scheduler.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its one result shows
// on result for exactly one cycle with done high and cannot be held off.
// Busy is already low in that cycle, so the next item can be taken at the edge
// that ends it. An enqueue checks the item and writes the descriptor in ST_ENQ,
// then the result shows. A dequeue that finds a descriptor first scans: a
// single priority comparator walks the channels one per cycle. ST_PICK then
// pops the head pointer and reads the descriptor memory, ST_READ loads the
// result register, and the result shows in the next cycle. A dequeue that
// finds every enabled queue empty skips ST_READ; ST_PICK loads the result
// register. Queue storage holds no reset value; only enqueued entries are
// ever read, so no clearing pass runs after reset.
module virtual_channel_priority_queues #(
	parameter int CHANNELS    = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vcpq_pkg::item_t   item,
	output logic              done,
	output vcpq_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import vcpq_pkg::*;

	localparam int CW = $clog2(CHANNELS);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = $clog2(CHANNELS * QUEUE_DEPTH + 1);
	localparam int MEM_WORDS = CHANNELS << PW;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ENQ  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_PICK = 5'b01000,
		ST_READ = 5'b10000
	} state_t;

	state_t state_q;

	logic [7:0]  enable_q;
	logic [31:0] prio_q;
	logic [63:0] len_low_q;
	logic [63:0] len_high_q;
	logic [4:0]  limit_q;

	item_t   req_q;
	logic [PW-1:0] head_q [CHANNELS];
	logic [NW-1:0] count_q [CHANNELS];
	logic [TW-1:0] total_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] best_q;
	logic [3:0]    best_prio_q;
	logic          found_q;

	entry_t mem [MEM_WORDS];
	entry_t rd_q;

	logic          done_q;
	result_t       res_q;
	result_t       res_d;

	logic [CW-1:0] sel_idx;
	logic [2:0]    sel_c3;
	logic [PW-1:0] cur_head;
	logic [NW-1:0] cur_count;
	logic          sel_enabled;
	logic [3:0]    sel_prio;
	logic          cand;
	logic [31:0]   eff_limit;
	logic [15:0]   req_len_cfg;
	logic          req_chan_ok;
	logic [2:0]    enq_code;
	logic          enq_ok;
	logic [31:0]   tail_sum;
	logic [PW-1:0] tail;
	logic [PW-1:0] head_next;
	logic [CW+PW-1:0] mem_addr;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		case (state_q)
			ST_ENQ:  sel_idx = CW'(req_q.channel_id);
			ST_SCAN: sel_idx = scan_q;
			default: sel_idx = best_q;
		endcase
		sel_c3      = 3'(sel_idx);
		cur_head    = head_q[sel_idx];
		cur_count   = count_q[sel_idx];
		sel_enabled = (32'(sel_idx) < 32'(CFG_CHANNELS)) && enable_q[sel_c3];
		sel_prio    = prio_q[4*sel_c3 +: 4];
		cand        = (cur_count != '0) && sel_enabled;

		eff_limit = (32'(limit_q) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : 32'(limit_q);
		req_len_cfg = req_q.channel_id[2] ? len_high_q[16*req_q.channel_id[1:0] +: 16]
		                                  : len_low_q[16*req_q.channel_id[1:0] +: 16];
		req_chan_ok = (32'(req_q.channel_id) < 32'(CHANNELS)) && enable_q[req_q.channel_id];
		if (!req_chan_ok) begin
			enq_code = RC_CHAN_OFF;
		end else if (req_q.sdu_length != req_len_cfg) begin
			enq_code = RC_LEN_BAD;
		end else if (32'(cur_count) >= eff_limit) begin
			enq_code = RC_FULL;
		end else begin
			enq_code = RC_OK;
		end
		enq_ok = (enq_code == RC_OK);

		tail_sum = 32'(cur_head) + 32'(cur_count);
		if (tail_sum >= 32'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - 32'(QUEUE_DEPTH);
		end
		tail = PW'(tail_sum);

		head_next = (32'(cur_head) == 32'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PW'(1);

		mem_addr = (state_q == ST_ENQ) ? {sel_idx, tail} : {sel_idx, cur_head};

		res_d = '0;
		case (state_q)
			ST_ENQ: begin
				res_d.result_code = enq_code;
				res_d.any_pending = (total_q != '0) || enq_ok;
			end
			ST_PICK: begin
				res_d.result_code = RC_EMPTY;
				res_d.any_pending = (total_q != '0);
			end
			ST_READ: begin
				res_d.result_code       = RC_OK;
				res_d.served_channel    = 3'(best_q);
				res_d.served_buffer_ref = rd_q.buffer_ref;
				res_d.served_length     = rd_q.length;
				res_d.served_status     = rd_q.status;
				res_d.any_pending       = (total_q != '0);
			end
			default: begin
			end
		endcase
	end

	// descriptor memory
	always_ff @(posedge clk) begin
		if (state_q == ST_ENQ && enq_ok) begin
			mem[mem_addr] <= '{status: req_q.sdu_status, length: req_q.sdu_length,
			                   buffer_ref: req_q.buffer_ref};
		end
		if (state_q == ST_PICK && found_q) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= item;
		end
		if (state_q == ST_SCAN && cand && (!found_q || sel_prio < best_prio_q)) begin
			best_q      <= scan_q;
			best_prio_q <= sel_prio;
		end
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			enable_q   <= '0;
			prio_q     <= '0;
			len_low_q  <= '0;
			len_high_q <= '0;
			limit_q    <= QUEUE_LIMIT_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			total_q <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_ENQ) || (state_q == ST_READ) ||
			          (state_q == ST_PICK && !found_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENABLE_MASK: enable_q   <= cfg_data[7:0];
					CFG_PRIORITIES:  prio_q     <= cfg_data[31:0];
					CFG_LEN_LOW:     len_low_q  <= cfg_data;
					CFG_LEN_HIGH:    len_high_q <= cfg_data;
					CFG_QUEUE_LIMIT: limit_q    <= cfg_data[4:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						state_q <= (item.opcode == OP_DEQUEUE) ? ST_SCAN : ST_ENQ;
					end
				end
				ST_ENQ: begin
					if (enq_ok) begin
						count_q[sel_idx] <= cur_count + NW'(1);
						total_q          <= total_q + TW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (cand) begin
						found_q <= 1'b1;
					end
					scan_q <= scan_q + CW'(1);
					if (scan_q == CW'(CHANNELS - 1)) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (found_q) begin
						head_q[sel_idx]  <= head_next;
						count_q[sel_idx] <= cur_count - NW'(1);
						total_q          <= total_q - TW'(1);
						state_q          <= ST_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[tb/virtual_channel_priority_queues_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_channel_priority_queues_test
// Drives enqueue and dequeue commands into the per-channel descriptor queues
// and checks every result beat against a cycle-free model of the scheduler:
// admission checks, FIFO order per channel, strict priority with ties to the
// lowest channel, and the pending flag. Directed cases come first, then
// random traffic over several register settings.
// ----------------------------------------------------------------------------
module virtual_channel_priority_queues_test;
	import vcpq_pkg::*;

	localparam int QUEUE_SLOTS = 16;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// scheduler model state
	logic [7:0]  m_mask;
	logic [31:0] m_prio;
	logic [63:0] m_len_lo;
	logic [63:0] m_len_hi;
	logic [4:0]  m_limit;
	entry_t      lane_store [CFG_CHANNELS][QUEUE_SLOTS];
	logic [3:0]  lane_head [CFG_CHANNELS];
	logic [4:0]  lane_count [CFG_CHANNELS];

	result_t awaited_results [$];
	int      errors;
	int      idle_pct;

	virtual_channel_priority_queues #(
		.CHANNELS    (CFG_CHANNELS),
		.QUEUE_DEPTH (QUEUE_SLOTS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] lane_length(input logic [2:0] ch);
		logic [127:0] lengths;
		lengths = {m_len_hi, m_len_lo};
		return lengths[ch * 16 +: 16];
	endfunction

	function automatic result_t schedule_item(input item_t it);
		result_t    r;
		logic [2:0] ch;
		logic [4:0] lim;
		logic [3:0] best_prio;
		logic [3:0] tail;
		int         best;
		entry_t     e;
		r = '0;
		lim = (m_limit > QUEUE_SLOTS) ? 5'(QUEUE_SLOTS) : m_limit;
		if (it.opcode == OP_ENQUEUE) begin
			ch = it.channel_id;
			if (!m_mask[ch]) begin
				r.result_code = RC_CHAN_OFF;
			end else if (it.sdu_length != lane_length(ch)) begin
				r.result_code = RC_LEN_BAD;
			end else if (lane_count[ch] >= lim) begin
				r.result_code = RC_FULL;
			end else begin
				tail = 4'(lane_head[ch] + lane_count[ch]);
				lane_store[ch][tail] = '{status: it.sdu_status, length: it.sdu_length,
					buffer_ref: it.buffer_ref};
				lane_count[ch]++;
				r.result_code = RC_OK;
			end
		end else begin
			best = -1;
			best_prio = '0;
			for (int c = 0; c < CFG_CHANNELS; c++) begin
				if (lane_count[c] != 0 && m_mask[c] && (best < 0 || m_prio[c * 4 +: 4] < best_prio)) begin
					best = c;
					best_prio = m_prio[c * 4 +: 4];
				end
			end
			if (best < 0) begin
				r.result_code = RC_EMPTY;
			end else begin
				e = lane_store[best][lane_head[best]];
				lane_head[best]++;
				lane_count[best]--;
				r.result_code = RC_OK;
				r.served_channel = 3'(best);
				r.served_buffer_ref = e.buffer_ref;
				r.served_length = e.length;
				r.served_status = e.status;
			end
		end
		for (int c = 0; c < CFG_CHANNELS; c++) begin
			if (lane_count[c] != 0) begin
				r.any_pending = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic item_t make_item(input logic op, input logic [2:0] ch,
		input logic [15:0] handle, input logic [15:0] len, input logic [7:0] st);
		item_t it;
		it.opcode = op;
		it.channel_id = ch;
		it.buffer_ref = handle;
		it.sdu_length = len;
		it.sdu_status = st;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		awaited_results.push_back(schedule_item(it));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		start = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] index, input logic [63:0] data);
		wait_drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_ENABLE_MASK: m_mask = data[7:0];
			CFG_PRIORITIES:  m_prio = data[31:0];
			CFG_LEN_LOW:     m_len_lo = data;
			CFG_LEN_HIGH:    m_len_hi = data;
			CFG_QUEUE_LIMIT: m_limit = data[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none actual %h", $time, result);
			end else begin
				want = awaited_results.pop_front();
				check_field("result_code", 16'(want.result_code), 16'(result.result_code));
				check_field("served_channel", 16'(want.served_channel),
					16'(result.served_channel));
				check_field("served_buffer_ref", want.served_buffer_ref,
					result.served_buffer_ref);
				check_field("served_length", want.served_length, result.served_length);
				check_field("served_status", 16'(want.served_status),
					16'(result.served_status));
				check_field("any_pending", 16'(want.any_pending), 16'(result.any_pending));
			end
		end
	end

	task automatic test_after_reset();
		send_item(make_item(OP_ENQUEUE, 3'd0, 16'h1234, 16'h0000, 8'h5a));
		send_item(make_item(OP_DEQUEUE, 3'd6, 16'hffff, 16'hffff, 8'hff));
	endtask

	task automatic test_admission_and_priority();
		write_register(CFG_ENABLE_MASK, 64'hffff_ffff_ffff_ffff);
		write_register(CFG_PRIORITIES, 64'h5555_aaaa_ef0f_0fff);
		write_register(CFG_LEN_LOW, 64'h3333_2222_1111_0000);
		write_register(CFG_LEN_HIGH, 64'hffff_6666_5555_4444);
		write_register(CFG_QUEUE_LIMIT, 64'd2);
		send_item(make_item(OP_ENQUEUE, 3'd7, 16'hffff, 16'hffff, 8'hff));
		send_item(make_item(OP_ENQUEUE, 3'd0, 16'h0000, 16'h0000, 8'h00));
		send_item(make_item(OP_ENQUEUE, 3'd0, 16'h0bad, 16'h0001, 8'h11));
		send_item(make_item(OP_ENQUEUE, 3'd0, 16'h00a1, 16'h0000, 8'h22));
		send_item(make_item(OP_ENQUEUE, 3'd0, 16'h00a2, 16'h0000, 8'h33));
		send_item(make_item(OP_ENQUEUE, 3'd3, 16'h0303, 16'h3333, 8'h44));
		send_item(make_item(OP_ENQUEUE, 3'd5, 16'h0505, 16'h5555, 8'h55));
		repeat (6) send_item(make_item(OP_DEQUEUE, 3'd0, 16'h0000, 16'h0000, 8'h00));
	endtask

	task automatic test_zero_limit();
		write_register(CFG_QUEUE_LIMIT, 64'hffff_ffff_ffff_ffe0);
		send_item(make_item(OP_ENQUEUE, 3'd1, 16'h7777, 16'h1111, 8'h77));
	endtask

	task automatic test_disabled_backlog();
		write_register(CFG_QUEUE_LIMIT, 64'd16);
		send_item(make_item(OP_ENQUEUE, 3'd2, 16'h2a2a, 16'h2222, 8'h2a));
		write_register(CFG_ENABLE_MASK, 64'h0000_0000_0000_00fb);
		send_item(make_item(OP_DEQUEUE, 3'd2, 16'h0000, 16'h0000, 8'h00));
		write_register(CFG_ENABLE_MASK, 64'h0000_0000_0000_00ff);
		send_item(make_item(OP_DEQUEUE, 3'd2, 16'h0000, 16'h0000, 8'h00));
	endtask

	task automatic randomize_config(input int phase, input logic [2:0] hot);
		logic [7:0]  mask;
		logic [31:0] prio;
		logic [4:0]  limits [8];
		limits = '{5'd16, 5'd3, 5'd31, 5'd8, 5'd1, 5'd17, 5'd2, 5'd16};
		mask = (phase == 0) ? 8'hff : (phase == 6) ? 8'h00 : 8'($urandom) | (8'd1 << hot);
		prio = (phase == 2) ? 32'h0 : (phase == 4) ? 32'hffff_ffff : $urandom;
		if (phase == 7) begin
			prio &= 32'h3333_3333;
		end
		write_register(CFG_ENABLE_MASK, {$urandom, 24'($urandom), mask});
		write_register(CFG_PRIORITIES, {$urandom, prio});
		write_register(CFG_LEN_LOW, (phase == 0) ? 64'h0 : {$urandom, $urandom});
		write_register(CFG_LEN_HIGH, (phase == 0) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom});
		write_register(CFG_QUEUE_LIMIT, {$urandom, 27'($urandom), limits[phase]});
	endtask

	task automatic test_random_traffic();
		item_t      it;
		int         deq_pct;
		logic [2:0] hot;
		logic [2:0] ch;
		for (int phase = 0; phase < 8; phase++) begin
			hot = 3'($urandom_range(7));
			randomize_config(phase, hot);
			idle_pct = (phase == 3) ? 0 : 21;
			deq_pct = 25;
			for (int n = 0; n < 200; n++) begin
				if (n % 40 == 0) begin
					deq_pct = ((n / 40) % 2 != 0) ? 70 : 25;
				end
				if (phase == 5 && n == 100) begin
					wait_drain();
				end
				ch = ($urandom_range(99) < 40) ? hot : 3'($urandom_range(7));
				it.opcode = ($urandom_range(99) < deq_pct) ? OP_DEQUEUE : OP_ENQUEUE;
				if (it.opcode == OP_ENQUEUE && $urandom_range(99) < 60 && m_mask != 8'h00) begin
					while (!m_mask[ch]) ch++;
				end
				it.channel_id = ch;
				it.buffer_ref = 16'($urandom);
				it.sdu_status = 8'($urandom);
				it.sdu_length = ($urandom_range(99) < 85) ? lane_length(ch) : 16'($urandom);
				send_item(it);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ENABLE_MASK;
		cfg_data = '0;
		errors = 0;
		idle_pct = 21;
		m_mask = '0;
		m_prio = '0;
		m_len_lo = '0;
		m_len_hi = '0;
		m_limit = QUEUE_LIMIT_RESET;
		for (int c = 0; c < CFG_CHANNELS; c++) begin
			lane_head[c] = '0;
			lane_count[c] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_admission_and_priority();
		test_zero_limit();
		test_disabled_backlog();
		test_random_traffic();

		wait_drain();
		repeat (CFG_CHANNELS + 8) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
